@@ design/mtx3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtx3_pkg
// Shared widths, word types and cofactor index tables for the 3x3 inverter.
// ----------------------------------------------------------------------------
package mtx3_pkg;

	localparam int FRAC_BITS = 16;
	localparam int EW   = 32;                 // element width
	localparam int PW   = 2 * EW;             // element product width
	localparam int CW   = PW + 1;             // cofactor width
	localparam int DW   = EW + CW + 2;        // determinant width
	localparam int SH   = 2 * FRAC_BITS;      // scale shift of the quotient numerator
	localparam int NW   = CW + SH;            // numerator width
	localparam int RW   = NW - EW;            // initial remainder width
	localparam int CMPW = (RW > DW) ? RW : DW;
	localparam int TW   = 31;                 // threshold width
	localparam int NLANE = 9;

	// Cofactor k = m[A]*m[B] - m[C]*m[D], already transposed into adjugate order.
	localparam logic [3:0] COF_A [NLANE] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
	localparam logic [3:0] COF_B [NLANE] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
	localparam logic [3:0] COF_C [NLANE] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
	localparam logic [3:0] COF_D [NLANE] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

	typedef struct packed {
		logic signed [EW-1:0] a00;
		logic signed [EW-1:0] a01;
		logic signed [EW-1:0] a02;
		logic signed [EW-1:0] a10;
		logic signed [EW-1:0] a11;
		logic signed [EW-1:0] a12;
		logic signed [EW-1:0] a20;
		logic signed [EW-1:0] a21;
		logic signed [EW-1:0] a22;
	} mat_in_t;

	typedef struct packed {
		logic signed [EW-1:0] inv00;
		logic signed [EW-1:0] inv01;
		logic signed [EW-1:0] inv02;
		logic signed [EW-1:0] inv10;
		logic signed [EW-1:0] inv11;
		logic signed [EW-1:0] inv12;
		logic signed [EW-1:0] inv20;
		logic signed [EW-1:0] inv21;
		logic signed [EW-1:0] inv22;
		logic signed [63:0]   det_value;
		logic                 invertible;
	} mat_out_t;

	// State of one divider lane as it moves down the quotient pipeline.
	typedef struct packed {
		logic [CW-1:0] absc;
		logic [DW-1:0] dmag;
		logic [DW-1:0] rem;
		logic [EW-1:0] quo;
		logic          ovf;
		logic          neg;
	} lane_t;

	// What the front end hands over besides the lanes.
	typedef struct packed {
		logic          vld;
		logic [63:0]   det_value;
		logic          ok;
	} front_ctl_t;

endpackage

@@ design/mtx3_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtx3_front
// Seven-stage front end: cofactors, determinant, magnitudes and lane setup.
// ----------------------------------------------------------------------------
module mtx3_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_fire,
	input  mtx3_pkg::mat_in_t                 mat,
	input  logic [mtx3_pkg::TW-1:0]           thr,
	output mtx3_pkg::front_ctl_t              ctl,
	output mtx3_pkg::lane_t                   lanes [mtx3_pkg::NLANE]
);

	logic signed [mtx3_pkg::EW-1:0] elem [9];
	logic [6:0] vld_s;

	logic signed [mtx3_pkg::PW-1:0] pa_s1 [mtx3_pkg::NLANE];
	logic signed [mtx3_pkg::PW-1:0] pb_s1 [mtx3_pkg::NLANE];
	logic signed [mtx3_pkg::EW-1:0] row_s1 [3];
	logic signed [mtx3_pkg::EW-1:0] row_s2 [3];
	logic signed [mtx3_pkg::CW-1:0] c_s2 [mtx3_pkg::NLANE];
	logic signed [mtx3_pkg::CW-1:0] c_s3 [mtx3_pkg::NLANE];
	logic signed [mtx3_pkg::CW-1:0] c_s4 [mtx3_pkg::NLANE];
	logic signed [mtx3_pkg::CW-1:0] c_s5 [mtx3_pkg::NLANE];
	logic signed [mtx3_pkg::CW-1:0] lo_s3 [3];
	logic signed [mtx3_pkg::CW-1:0] hi_s3 [3];
	logic signed [mtx3_pkg::DW-1:0] t_s4 [3];
	logic signed [mtx3_pkg::DW-1:0] det_s5;
	logic                           dneg_s6;
	logic [mtx3_pkg::DW-1:0]        dmag_s6;
	logic [mtx3_pkg::CW-1:0]        absc_s6 [mtx3_pkg::NLANE];
	logic [mtx3_pkg::NLANE-1:0]     cneg_s6;
	logic [63:0]                    detv_s7;
	logic                           ok_s7;
	logic [mtx3_pkg::DW-1:0]        mag;

	assign elem[0] = mat.a00;
	assign elem[1] = mat.a01;
	assign elem[2] = mat.a02;
	assign elem[3] = mat.a10;
	assign elem[4] = mat.a11;
	assign elem[5] = mat.a12;
	assign elem[6] = mat.a20;
	assign elem[7] = mat.a21;
	assign elem[8] = mat.a22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[5:0], in_fire};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < mtx3_pkg::NLANE; k++) begin
				pa_s1[k] <= mtx3_pkg::PW'(elem[mtx3_pkg::COF_A[k]])
					* mtx3_pkg::PW'(elem[mtx3_pkg::COF_B[k]]);
				pb_s1[k] <= mtx3_pkg::PW'(elem[mtx3_pkg::COF_C[k]])
					* mtx3_pkg::PW'(elem[mtx3_pkg::COF_D[k]]);
				c_s2[k] <= mtx3_pkg::CW'(pa_s1[k]) - mtx3_pkg::CW'(pb_s1[k]);
				c_s3[k] <= c_s2[k];
				c_s4[k] <= c_s3[k];
				c_s5[k] <= c_s4[k];
				cneg_s6[k] <= c_s5[k][mtx3_pkg::CW-1];
				absc_s6[k] <= c_s5[k][mtx3_pkg::CW-1] ? mtx3_pkg::CW'(-c_s5[k])
					: mtx3_pkg::CW'(c_s5[k]);
			end
			for (int j = 0; j < 3; j++) begin
				row_s1[j] <= elem[j];
				row_s2[j] <= row_s1[j];
				// First-row expansion uses cofactors 0, 3 and 6; the wide cofactor
				// is split into an unsigned low half and a signed high half.
				lo_s3[j] <= row_s2[j] * $signed({1'b0, c_s2[3*j][mtx3_pkg::EW-1:0]});
				hi_s3[j] <= row_s2[j]
					* $signed(c_s2[3*j][mtx3_pkg::CW-1:mtx3_pkg::EW]);
				t_s4[j] <= (mtx3_pkg::DW'(hi_s3[j]) <<< mtx3_pkg::EW)
					+ mtx3_pkg::DW'(lo_s3[j]);
			end
			det_s5  <= t_s4[0] + t_s4[1] + t_s4[2];
			dneg_s6 <= det_s5[mtx3_pkg::DW-1];
			dmag_s6 <= det_s5[mtx3_pkg::DW-1] ? mtx3_pkg::DW'(-det_s5)
				: mtx3_pkg::DW'(det_s5);
		end
	end

	assign mag = dmag_s6 >> mtx3_pkg::SH;

	always_ff @(posedge clk) begin
		logic [mtx3_pkg::NW-1:0] num;
		logic [mtx3_pkg::RW-1:0] r0;
		if (en) begin
			if (dneg_s6) begin
				detv_s7 <= (mag > mtx3_pkg::DW'(64'h8000_0000_0000_0000))
					? 64'h8000_0000_0000_0000 : 64'(-mag);
			end else begin
				detv_s7 <= (mag > mtx3_pkg::DW'(64'h7FFF_FFFF_FFFF_FFFF))
					? 64'h7FFF_FFFF_FFFF_FFFF : mag[63:0];
			end
			ok_s7 <= dmag_s6 > (mtx3_pkg::DW'(thr) << mtx3_pkg::SH);
			for (int k = 0; k < mtx3_pkg::NLANE; k++) begin
				num = mtx3_pkg::NW'(absc_s6[k]) << mtx3_pkg::SH;
				r0  = num[mtx3_pkg::NW-1:mtx3_pkg::EW];
				lanes[k].absc <= absc_s6[k];
				lanes[k].dmag <= dmag_s6;
				lanes[k].rem  <= mtx3_pkg::DW'(r0);
				lanes[k].quo  <= '0;
				// A quotient of 2^32 or more is flagged here and saturates at the end.
				lanes[k].ovf  <= mtx3_pkg::CMPW'(r0) >= mtx3_pkg::CMPW'(dmag_s6);
				lanes[k].neg  <= cneg_s6[k] ^ dneg_s6;
			end
		end
	end

	assign ctl.vld       = vld_s[6];
	assign ctl.det_value = detv_s7;
	assign ctl.ok        = ok_s7;

endmodule

@@ design/mtx3_div_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtx3_div_lane
// One restoring-division lane: one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module mtx3_div_lane (
	input  logic            clk,
	input  logic            en,
	input  mtx3_pkg::lane_t init,
	output mtx3_pkg::lane_t result
);

	mtx3_pkg::lane_t st [mtx3_pkg::EW+1];

	assign st[0] = init;

	for (genvar k = 0; k < mtx3_pkg::EW; k++) begin : g_step
		localparam int BIT = mtx3_pkg::EW - 1 - k;
		logic                    nb;
		logic [mtx3_pkg::DW:0]   trial;
		logic                    ge;

		// The numerator bit brought down at this step; below the scale shift it is zero.
		if (BIT >= mtx3_pkg::SH) begin : g_bit
			assign nb = st[k].absc[BIT - mtx3_pkg::SH];
		end else begin : g_zero
			assign nb = 1'b0;
		end

		assign trial = {st[k].rem, nb};
		assign ge    = trial >= {1'b0, st[k].dmag};

		always_ff @(posedge clk) begin
			if (en) begin
				st[k+1].absc <= st[k].absc;
				st[k+1].dmag <= st[k].dmag;
				st[k+1].rem  <= ge ? mtx3_pkg::DW'(trial - {1'b0, st[k].dmag})
					: mtx3_pkg::DW'(trial);
				st[k+1].quo  <= {st[k].quo[mtx3_pkg::EW-2:0], ge};
				st[k+1].ovf  <= st[k].ovf;
				st[k+1].neg  <= st[k].neg;
			end
		end
	end

	assign result = st[mtx3_pkg::EW];

endmodule

@@ design/matrix3_inverse_with_determinant.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_with_determinant
// 3x3 fixed-point inverse by adjugate over determinant, nine divider lanes.
//
//   channel   signals                         word
//   in        in_valid in_ready in_data       mat_in_t, one matrix
//   out       out_valid out_ready out_data    mat_out_t, inverse and determinant
//   cfg       cfg_valid cfg_ready cfg_data    singular threshold, always ready
//
// One matrix per cycle unless the output stalls; it has 7 front-end stages,
// 32 quotient stages (one bit each in every lane) and the output register.
// Reset clears all valid bits and sets the threshold to 1.
// The whole pipeline holds while a finished word waits at the output.
// ----------------------------------------------------------------------------
module matrix3_inverse_with_determinant (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  mtx3_pkg::mat_in_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output mtx3_pkg::mat_out_t          out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mtx3_pkg::TW-1:0]     cfg_data
);

	logic                         en;
	logic [mtx3_pkg::TW-1:0]      thr_q;
	logic                         out_valid_q;
	mtx3_pkg::mat_out_t           out_q;
	mtx3_pkg::front_ctl_t         ctl;
	mtx3_pkg::front_ctl_t         side_s [mtx3_pkg::EW+1];
	mtx3_pkg::lane_t              lane_init [mtx3_pkg::NLANE];
	mtx3_pkg::lane_t              lane_res [mtx3_pkg::NLANE];
	logic signed [mtx3_pkg::EW-1:0] inv_val [mtx3_pkg::NLANE];

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= mtx3_pkg::TW'(1);
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	mtx3_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_fire (in_valid && en),
		.mat     (in_data),
		.thr     (thr_q),
		.ctl     (ctl),
		.lanes   (lane_init)
	);

	for (genvar k = 0; k < mtx3_pkg::NLANE; k++) begin : g_lane
		mtx3_div_lane u_lane (
			.clk    (clk),
			.en     (en),
			.init   (lane_init[k]),
			.result (lane_res[k])
		);
	end

	// Determinant and verdict ride alongside the divider stages.
	assign side_s[0] = ctl;
	for (genvar k = 0; k < mtx3_pkg::EW; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k+1] <= '0;
			end else if (en) begin
				side_s[k+1] <= side_s[k];
			end
		end
	end

	// Merge: sign, saturation and the singular case for all nine lanes.
	always_comb begin
		for (int k = 0; k < mtx3_pkg::NLANE; k++) begin
			if (!side_s[mtx3_pkg::EW].ok) begin
				inv_val[k] = '0;
			end else if (lane_res[k].neg) begin
				if (lane_res[k].ovf || lane_res[k].quo > 32'h8000_0000) begin
					inv_val[k] = 32'sh8000_0000;
				end else begin
					inv_val[k] = $signed(-lane_res[k].quo);
				end
			end else begin
				if (lane_res[k].ovf || lane_res[k].quo[mtx3_pkg::EW-1]) begin
					inv_val[k] = 32'sh7FFF_FFFF;
				end else begin
					inv_val[k] = $signed(lane_res[k].quo);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= side_s[mtx3_pkg::EW].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.inv00      <= inv_val[0];
			out_q.inv01      <= inv_val[1];
			out_q.inv02      <= inv_val[2];
			out_q.inv10      <= inv_val[3];
			out_q.inv11      <= inv_val[4];
			out_q.inv12      <= inv_val[5];
			out_q.inv20      <= inv_val[6];
			out_q.inv21      <= inv_val[7];
			out_q.inv22      <= inv_val[8];
			out_q.det_value  <= side_s[mtx3_pkg::EW].det_value;
			out_q.invertible <= side_s[mtx3_pkg::EW].ok;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.invertible |->
			out_data.inv00 == 0 && out_data.inv01 == 0 && out_data.inv02 == 0 &&
			out_data.inv10 == 0 && out_data.inv11 == 0 && out_data.inv12 == 0 &&
			out_data.inv20 == 0 && out_data.inv21 == 0 && out_data.inv22 == 0)
		else $error("singular word carries a nonzero inverse element");

	a_invertible_det: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.invertible && out_data.det_value == 0 |-> thr_q == 0)
		else $error("invertible word with a zero determinant above threshold");
`endif

endmodule
